/* design/ctse_pkg.sv */
// Shared types and constants for the asctime line to epoch converter.
// Used by ctse_front, ctse_fifo, ctse_back and ctime_string_to_epoch.
// Depends on nothing.
package ctse_pkg;

	// Line layout and character codes
	localparam logic [4:0] LINE_LEN     = 5'd24;
	localparam logic [7:0] DIGIT_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// Fixed character positions within the line
	localparam logic [4:0] POS_MON0     = 5'd4;
	localparam logic [4:0] POS_MON1     = 5'd5;
	localparam logic [4:0] POS_MON2     = 5'd6;
	localparam logic [4:0] POS_DAY_T    = 5'd8;
	localparam logic [4:0] POS_DAY_U    = 5'd9;
	localparam logic [4:0] POS_HOUR_T   = 5'd11;
	localparam logic [4:0] POS_HOUR_U   = 5'd12;
	localparam logic [4:0] POS_MIN_T    = 5'd14;
	localparam logic [4:0] POS_MIN_U    = 5'd15;
	localparam logic [4:0] POS_SEC_T    = 5'd17;
	localparam logic [4:0] POS_SEC_U    = 5'd18;
	localparam logic [4:0] POS_YEAR_0   = 5'd20;
	localparam logic [4:0] POS_YEAR_1   = 5'd21;
	localparam logic [4:0] POS_YEAR_2   = 5'd22;
	localparam logic [4:0] POS_YEAR_3   = 5'd23;

	localparam int         NUM_MONTHS   = 12;
	localparam logic [3:0] MONTH_MAR    = 4'd2;

	// Three-letter month names, first letter in the high byte
	localparam logic [23:0] MONTH_NAME [NUM_MONTHS] = '{
		24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
		24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
	};

	// Day of a March-based year on which each month starts (Jan first)
	localparam logic [8:0] MONTH_DOY [NUM_MONTHS] = '{
		9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
		9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
	};

	// Year bias keeps the era division on non-negative values
	localparam logic signed [19:0] YEAR_BIAS  = 20'sd80000;
	localparam logic signed [10:0] ERA_BIAS   = 11'sd200;
	localparam logic [26:0]        RECIP_25   = 27'd5243;
	localparam logic [18:0]        ERA_YEARS  = 19'd400;
	localparam logic [13:0]        RECIP_100  = 14'd41;
	localparam logic signed [28:0] ERA_DAYS   = 29'sd146097;
	localparam logic signed [28:0] EPOCH_DAYS = 29'sd719468;
	localparam logic signed [45:0] DAY_SECS   = 46'sd86400;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] epoch_seconds;
		logic               error;
	} out_item_t;

	// One parsed line handed from the front to the back
	typedef struct packed {
		logic               error;
		logic [3:0]         month_idx;
		logic signed [12:0] day;
		logic signed [12:0] hour;
		logic signed [12:0] minute;
		logic signed [12:0] second;
		logic signed [18:0] year;
	} line_t;

endpackage

/* design/ctime_string_to_epoch.sv */
// asctime line ("Www Mmm dd hh:mm:ss yyyy") to Unix seconds, one character per item.
// Throughput: one character per cycle while the record queue has room.
// Path: the record of each line waits in a QUEUE_DEPTH record queue, then passes
// through the eight-stage conversion pipeline to the output.
// Reset clears line state, queue and pipeline at once; zone offset resets to 0.
// Depends on ctse_pkg, ctse_front, ctse_fifo and ctse_back.
module ctime_string_to_epoch #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ctse_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ctse_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic signed [16:0]   cfg_data
);

	logic signed [16:0] zone_q;
	logic               rec_valid, rec_ready;
	ctse_pkg::line_t    rec_data;
	logic               pop_valid, pop_ready;
	ctse_pkg::line_t    pop_data;

	// Hold the zone offset register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			zone_q <= cfg_data;
		end
	end

	ctse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_data  (rec_data)
	);

	ctse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rec_valid),
		.push_ready (rec_ready),
		.push_data  (rec_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ctse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.zone      (zone_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* design/ctse_front.sv */
// Character parser: accumulates fixed-position fields of one line.
// Emits one ctse_pkg::line_t record per line; depends on ctse_pkg.
module ctse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ctse_pkg::in_item_t   in_item,
	output logic                 rec_valid,
	input  logic                 rec_ready,
	output ctse_pkg::line_t      rec_data
);

	logic [4:0]         position_q, pos_n;
	logic [23:0]        month_q, month_n;
	logic signed [12:0] day_q, day_n;
	logic signed [12:0] hour_q, hour_n;
	logic signed [12:0] minute_q, minute_n;
	logic signed [12:0] second_q, second_n;
	logic signed [18:0] year_q, year_n;
	logic signed [8:0]  dv;
	logic signed [12:0] dv13;
	logic signed [12:0] tens;
	logic signed [18:0] dv19;
	logic               accept;
	logic               hit;
	logic [3:0]         idx;

	assign in_ready = rec_ready;
	assign accept   = in_valid && in_ready;

	// Digit value and tens contribution; a space in a tens place is zero
	assign dv   = $signed({1'b0, in_item.char_code}) - $signed({1'b0, ctse_pkg::DIGIT_ZERO});
	assign dv13 = 13'(dv);
	assign dv19 = 19'(dv);
	assign tens = (in_item.char_code == ctse_pkg::CHAR_SPACE) ? 13'sd0 : dv13 * 13'sd10;

	// Update the field that the current position feeds
	always_comb begin
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		year_n   = year_q;
		case (position_q)
			ctse_pkg::POS_MON0, ctse_pkg::POS_MON1, ctse_pkg::POS_MON2: begin
				month_n = {month_q[15:0], in_item.char_code};
			end
			ctse_pkg::POS_DAY_T:  day_n    = tens;
			ctse_pkg::POS_DAY_U:  day_n    = day_q + dv13;
			ctse_pkg::POS_HOUR_T: hour_n   = tens;
			ctse_pkg::POS_HOUR_U: hour_n   = hour_q + dv13;
			ctse_pkg::POS_MIN_T:  minute_n = tens;
			ctse_pkg::POS_MIN_U:  minute_n = minute_q + dv13;
			ctse_pkg::POS_SEC_T:  second_n = tens;
			ctse_pkg::POS_SEC_U:  second_n = second_q + dv13;
			ctse_pkg::POS_YEAR_0: year_n   = dv19 * 19'sd1000;
			ctse_pkg::POS_YEAR_1: year_n   = year_q + dv19 * 19'sd100;
			ctse_pkg::POS_YEAR_2: year_n   = year_q + dv19 * 19'sd10;
			ctse_pkg::POS_YEAR_3: year_n   = year_q + dv19;
			default: ;
		endcase
		pos_n = (position_q < ctse_pkg::LINE_LEN) ? position_q + 5'd1 : position_q;
	end

	// Match the month name against the table
	always_comb begin
		hit = 1'b0;
		idx = 4'd0;
		for (int i = 0; i < ctse_pkg::NUM_MONTHS; i++) begin
			if (!hit && month_n == ctse_pkg::MONTH_NAME[i]) begin
				hit = 1'b1;
				idx = 4'(i);
			end
		end
	end

	// Build the record for the last item of a line
	assign rec_valid          = accept && in_item.is_last;
	assign rec_data.error     = (pos_n < ctse_pkg::LINE_LEN) || !hit;
	assign rec_data.month_idx = idx;
	assign rec_data.day       = day_n;
	assign rec_data.hour      = hour_n;
	assign rec_data.minute    = minute_n;
	assign rec_data.second    = second_n;
	assign rec_data.year      = year_n;

	// Hold line state; clear it after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			year_q     <= '0;
		end else if (accept) begin
			if (in_item.is_last) begin
				position_q <= '0;
				month_q    <= '0;
				day_q      <= '0;
				hour_q     <= '0;
				minute_q   <= '0;
				second_q   <= '0;
				year_q     <= '0;
			end else begin
				position_q <= pos_n;
				month_q    <= month_n;
				day_q      <= day_n;
				hour_q     <= hour_n;
				minute_q   <= minute_n;
				second_q   <= second_n;
				year_q     <= year_n;
			end
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= ctse_pkg::LINE_LEN)
		else $error("position counter passed line length");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.is_last) |=> (position_q == 5'd0 && year_q == 19'sd0))
		else $error("line state not cleared after last item");

endmodule

/* design/ctse_fifo.sv */
// Short record queue between the parser and the conversion pipeline.
// Stores ctse_pkg::line_t records in flops; depends on ctse_pkg.
module ctse_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  ctse_pkg::line_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output ctse_pkg::line_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ctse_pkg::line_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Write the incoming record
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");

endmodule

/* design/ctse_back.sv */
// Conversion pipeline: civil date and time of one record to Unix seconds.
// Eight stages with a common stall; the last stage is the output register.
// Depends on ctse_pkg.
module ctse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [16:0]   zone,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  ctse_pkg::line_t      pop_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ctse_pkg::out_item_t  out_item
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// Carried fields
	logic               err_s1, err_s2, err_s3, err_s4, err_s5, err_s6, err_s7, err_s8;
	logic [8:0]         doy_s1, doy_s2, doy_s3;
	logic signed [12:0] day_s1, day_s2, day_s3, day_s4, day_s5;
	logic signed [12:0] hour_s1, hour_s2, hour_s3, hour_s4;
	logic signed [12:0] min_s1, min_s2, min_s3, min_s4;
	logic signed [12:0] sec_s1, sec_s2, sec_s3, sec_s4, sec_s5;

	// Computed values
	logic [18:0]        n_s1, n_s2;
	logic [9:0]         q_s2;
	logic [8:0]         yoe_s3;
	logic signed [10:0] era_s3, era_s4;
	logic [17:0]        doe_s4, doe_s5;
	logic signed [28:0] era_mul_s5;
	logic signed [25:0] hour_mul_s5;
	logic signed [19:0] min_mul_s5;
	logic signed [28:0] days_s6;
	logic signed [25:0] tod_s6, tod_s7;
	logic signed [45:0] prod_s7;
	logic signed [63:0] epoch_s8;

	logic signed [19:0] ysub;
	logic signed [19:0] nbias;
	logic [26:0]        recip;
	logic [13:0]        t41;

	// Advance every stage unless the output register is stalled
	assign en        = !v_s8 || out_ready;
	assign pop_ready = en;

	// Stage 1: shift Jan and Feb into the previous year, bias positive
	assign ysub  = 20'(pop_data.year)
		- ((pop_data.month_idx < ctse_pkg::MONTH_MAR) ? 20'sd1 : 20'sd0);
	assign nbias = ysub + ctse_pkg::YEAR_BIAS;

	// Stage 2: divide by 400 as (n / 16) / 25 through a reciprocal
	assign recip = 27'(n_s1[18:4]) * ctse_pkg::RECIP_25;

	// Stage 4: yoe / 100 through a reciprocal
	assign t41 = 14'(yoe_s3) * ctse_pkg::RECIP_100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			n_s1    <= nbias[18:0];
			doy_s1  <= ctse_pkg::MONTH_DOY[pop_data.month_idx];
			err_s1  <= pop_data.error;
			day_s1  <= pop_data.day;
			hour_s1 <= pop_data.hour;
			min_s1  <= pop_data.minute;
			sec_s1  <= pop_data.second;
			// Stage 2
			n_s2    <= n_s1;
			q_s2    <= recip[26:17];
			doy_s2  <= doy_s1;
			err_s2  <= err_s1;
			day_s2  <= day_s1;
			hour_s2 <= hour_s1;
			min_s2  <= min_s1;
			sec_s2  <= sec_s1;
			// Stage 3: year of era and era
			yoe_s3  <= 9'(n_s2 - 19'(q_s2) * ctse_pkg::ERA_YEARS);
			era_s3  <= $signed({1'b0, q_s2}) - ctse_pkg::ERA_BIAS;
			doy_s3  <= doy_s2;
			err_s3  <= err_s2;
			day_s3  <= day_s2;
			hour_s3 <= hour_s2;
			min_s3  <= min_s2;
			sec_s3  <= sec_s2;
			// Stage 4: day of era
			doe_s4  <= 18'(yoe_s3) * 18'd365 + 18'(yoe_s3[8:2])
				- 18'(t41[13:12]) + 18'(doy_s3);
			era_s4  <= era_s3;
			err_s4  <= err_s3;
			day_s4  <= day_s3;
			hour_s4 <= hour_s3;
			min_s4  <= min_s3;
			sec_s4  <= sec_s3;
			// Stage 5: constant products
			era_mul_s5  <= 29'(era_s4) * ctse_pkg::ERA_DAYS;
			hour_mul_s5 <= 26'(hour_s4) * 26'sd3600;
			min_mul_s5  <= 20'(min_s4) * 20'sd60;
			doe_s5      <= doe_s4;
			err_s5      <= err_s4;
			day_s5      <= day_s4;
			sec_s5      <= sec_s4;
			// Stage 6: day count and time of day less zone offset
			days_s6 <= era_mul_s5 + $signed({11'b0, doe_s5}) - ctse_pkg::EPOCH_DAYS
				+ 29'(day_s5) - 29'sd1;
			tod_s6  <= hour_mul_s5 + 26'(min_mul_s5) + 26'(sec_s5) - 26'(zone);
			err_s6  <= err_s5;
			// Stage 7: days to seconds
			prod_s7 <= 46'(days_s6) * ctse_pkg::DAY_SECS;
			tod_s7  <= tod_s6;
			err_s7  <= err_s6;
			// Stage 8: final sum, or all ones on error
			epoch_s8 <= err_s7 ? -64'sd1 : 64'(prod_s7) + 64'(tod_s7);
			err_s8   <= err_s7;
		end
	end

	assign out_valid              = v_s8;
	assign out_item.epoch_seconds = epoch_s8;
	assign out_item.error         = err_s8;

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.error) |-> (out_item.epoch_seconds == -64'sd1))
		else $error("error result without all-ones seconds");

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> v_s1)
		else $error("popped record did not enter the pipeline");

endmodule

/* verif/ctse_epoch_checker.sv */
`timescale 1ns / 1ps
// Result checker for ctime_string_to_epoch: watches the character, result and zone channels,
// predicts the epoch for each line and compares every result field by field.
// Depends on ctse_pkg for the item types.
module ctse_epoch_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ctse_pkg::in_item_t   in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ctse_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic signed [16:0]   cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam int LINE_CHARS = 24;

	// Zone offset and the line being parsed
	logic signed [16:0]   zone_offset;
	logic [4:0]           char_pos;
	logic [23:0]          month_word;
	int                   day_acc;
	int                   hour_acc;
	int                   min_acc;
	int                   sec_acc;
	int                   year_acc;
	ctse_pkg::out_item_t  expected_epochs[$];

	// Month index 0..11 for a three-letter name, -1 when unknown
	function automatic int month_of(input logic [23:0] word);
		case (word)
		"Jan": return 0;
		"Feb": return 1;
		"Mar": return 2;
		"Apr": return 3;
		"May": return 4;
		"Jun": return 5;
		"Jul": return 6;
		"Aug": return 7;
		"Sep": return 8;
		"Oct": return 9;
		"Nov": return 10;
		"Dec": return 11;
		default: return -1;
		endcase
	endfunction

	// Days from 1970-01-01 to the first of month mo (1..12) of year y
	function automatic longint month_start_days(input longint y, input int mo);
		longint era, yoe, doy, doe;
		if (mo <= 2) begin
			y = y - 1;
		end
		era = (y >= 0 ? y : y - 399) / 400;
		yoe = y - era * 400;
		doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	task automatic clear_line();
		char_pos   = '0;
		month_word = '0;
		day_acc    = 0;
		hour_acc   = 0;
		min_acc    = 0;
		sec_acc    = 0;
		year_acc   = 0;
	endtask

	// Fold one character into the line; on the last one queue the expected result
	task automatic take_char(input logic [7:0] c, input logic last);
		int                  digit, tens, mon;
		longint              days, secs;
		ctse_pkg::out_item_t want;
		digit = int'(c) - 48;
		tens  = (c == 8'h20) ? 0 : digit * 10;
		// fixed layout: "Www Mmm dd hh:mm:ss yyyy"
		case (char_pos)
		5'd4, 5'd5, 5'd6: month_word = {month_word[15:0], c};
		5'd8:  day_acc  = tens;
		5'd9:  day_acc  = day_acc + digit;
		5'd11: hour_acc = tens;
		5'd12: hour_acc = hour_acc + digit;
		5'd14: min_acc  = tens;
		5'd15: min_acc  = min_acc + digit;
		5'd17: sec_acc  = tens;
		5'd18: sec_acc  = sec_acc + digit;
		5'd20: year_acc = digit * 1000;
		5'd21: year_acc = year_acc + digit * 100;
		5'd22: year_acc = year_acc + digit * 10;
		5'd23: year_acc = year_acc + digit;
		default: ;
		endcase
		if (char_pos < LINE_CHARS) begin
			char_pos = char_pos + 5'd1;
		end
		if (!last) begin
			return;
		end

		mon = month_of(month_word);
		if (char_pos < LINE_CHARS || mon < 0) begin
			want.epoch_seconds = -64'sd1;
			want.error         = 1'b1;
		end else begin
			days = month_start_days(longint'(year_acc), mon + 1) + longint'(day_acc) - 1;
			secs = days * 86400 + longint'(hour_acc) * 3600 + longint'(min_acc) * 60
				+ longint'(sec_acc) - longint'(zone_offset);
			want.epoch_seconds = secs;
			want.error         = 1'b0;
		end
		expected_epochs.push_back(want);
		clear_line();
	endtask

	// Compare one delivered result with the oldest expectation
	task automatic check_result();
		ctse_pkg::out_item_t want;
		if (expected_epochs.size() == 0) begin
			$error("result with nothing expected: epoch_seconds %0d error %0b",
				out_item.epoch_seconds, out_item.error);
			fail_count++;
			return;
		end
		want = expected_epochs.pop_front();
		if (out_item.error !== want.error) begin
			$error("error: expected %0b, got %0b", want.error, out_item.error);
			fail_count++;
		end
		if (out_item.epoch_seconds !== want.epoch_seconds) begin
			$error("epoch_seconds: expected %0d, got %0d", want.epoch_seconds,
				out_item.epoch_seconds);
			fail_count++;
		end
	endtask

	// Track every channel at the rising edge; results first, then the new item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset = '0;
			clear_line();
			expected_epochs.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				zone_offset = cfg_data;
			end
			if (out_valid && out_ready) begin
				check_result();
			end
			if (in_valid && in_ready) begin
				take_char(in_item.char_code, in_item.is_last);
			end
			pending <= expected_epochs.size();
		end
	end

endmodule

/* verif/ctime_string_to_epoch_tb.sv */
`timescale 1ns / 1ps
// Top of the ctime_string_to_epoch testbench: clock, reset, line stimulus, result back-pressure
// and zone offset writes. Depends on ctse_pkg, the block and ctse_epoch_checker.
module ctime_string_to_epoch_tb;

	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_CYCLES = 2000;
	localparam int HOLD_AFTER  = 16;
	localparam int SETTLE      = 12;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	ctse_pkg::in_item_t   in_item;
	logic                 out_valid;
	logic                 out_ready;
	ctse_pkg::out_item_t  out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic signed [16:0]   cfg_data;
	int                   fail_count;
	int                   pending;
	int                   results_seen = 0;
	logic [7:0]           line_chars[$];

	ctime_string_to_epoch u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ctse_epoch_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
		end
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one character and hold it until accepted
	task automatic send_char(input logic [7:0] c, input logic last, input logic burst);
		int gap;
		gap = burst ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{char_code: c, is_last: last};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_line();
		logic burst;
		burst = ($urandom_range(0, 4) == 0);
		foreach (line_chars[i]) begin
			send_char(line_chars[i], i == line_chars.size() - 1, burst);
		end
	endtask

	task automatic text_line(input string s);
		line_chars.delete();
		for (int i = 0; i < s.len(); i++) begin
			line_chars.push_back(s[i]);
		end
	endtask

	// Overwrite every digit position of the current line
	task automatic fill_digits(input logic [7:0] c);
		int digit_pos[12] = '{8, 9, 11, 12, 14, 15, 17, 18, 20, 21, 22, 23};
		foreach (digit_pos[i]) begin
			line_chars[digit_pos[i]] = c;
		end
	endtask

	task automatic good_line(input int mon, input int day, input int hour, input int minute,
			input int second, input int year);
		string weeks, months;
		int    w;
		weeks  = "SunMonTueWedThuFriSat";
		months = "JanFebMarAprMayJunJulAugSepOctNovDec";
		w      = $urandom_range(0, 6);
		text_line($sformatf("%s %s %2d %02d:%02d:%02d %04d", weeks.substr(3 * w, 3 * w + 2),
			months.substr(3 * mon, 3 * mon + 2), day, hour, minute, second, year));
	endtask

	// Mostly well-formed lines, the rest short, long, misspelled, with corrupted digits or noise
	task automatic random_line();
		int digit_pos[12] = '{8, 9, 11, 12, 14, 15, 17, 18, 20, 21, 22, 23};
		int tens_pos[3]   = '{11, 14, 17};
		int kind, n, p;
		kind = $urandom_range(0, 99);
		good_line($urandom_range(0, 11),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59),
			($urandom_range(0, 4) == 0) ? $urandom_range(0, 9999) : $urandom_range(1900, 2099));
		if (kind < 70) begin
			// blank a zero tens digit now and then
			foreach (tens_pos[i]) begin
				if (line_chars[tens_pos[i]] == "0" && $urandom_range(0, 9) == 0) begin
					line_chars[tens_pos[i]] = " ";
				end
			end
		end else if (kind < 78) begin
			n = $urandom_range(1, 23);
			while (line_chars.size() > n) void'(line_chars.pop_back());
		end else if (kind < 84) begin
			repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			p = 4 + $urandom_range(0, 2);
			n = $urandom_range(0, 2);
			if (n == 0) begin
				line_chars[p] = line_chars[p] ^ 8'h20;
			end else if (n == 1) begin
				line_chars[p] = 8'($urandom_range(0, 255));
			end else begin
				line_chars[4] = "O";
				line_chars[5] = "p";
				line_chars[6] = "t";
			end
		end else if (kind < 96) begin
			repeat ($urandom_range(1, 4)) begin
				line_chars[digit_pos[$urandom_range(0, 11)]] = 8'($urandom_range(0, 255));
			end
		end else begin
			line_chars.delete();
			repeat ($urandom_range(1, 40)) line_chars.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Stop offering, wait for every result, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_zone(input logic signed [16:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random ready with one long hold-off while the sender keeps going
	initial begin : result_sink
		logic hold_done;
		int   gap;
		hold_done = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = idle_len();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	// End the run when nothing moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int zones[7];
		int phase_lines[7];
		in_valid     = 1'b0;
		in_item      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed lines at the reset zone offset
		text_line("Thu Jan  1 00:00:00 1970");
		send_line();
		text_line("Tue Feb 29 23:59:59 2000");
		send_line();
		text_line("Fri Dec 31 23:59:59 9999");
		send_line();
		text_line("Sat Jan  0 00:00:00 0000");
		send_line();
		text_line("Sun Opt 10 12:00:00 2021");
		send_line();
		text_line("Mon jan 01 12:00:00 2021");
		send_line();
		text_line("X");
		send_line();
		text_line("Wed Mar 15 08:30:00 202");
		send_line();
		text_line("Thu Apr 30 11:22:33 2010 extra text");
		send_line();
		text_line("Fri Mar 11 11:11:11 1111");
		fill_digits(8'hFF);
		send_line();
		text_line("Sat Nov 11 11:11:11 1111");
		fill_digits(8'h00);
		send_line();
		text_line("Wed Aug 99 99:99:99 1999");
		send_line();
		text_line("Wed Sep  5  7: 8: 9 2024");
		send_line();
		drain();

		// Random lines over several zone offsets, extremes included
		zones       = '{-50400, 50400, -65536, 65535, 0, 0, 0};
		zones[4]    = int'($urandom_range(0, 100800)) - 50400;
		zones[5]    = int'($urandom_range(0, 100800)) - 50400;
		phase_lines = '{27, 7, 7, 7, 7, 7, 7};
		for (int p = 0; p < 7; p++) begin
			write_zone(17'(zones[p]));
			repeat (phase_lines[p]) begin
				random_line();
				send_line();
			end
			drain();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
